@@ rtl/core/keypad_code_alarm_controller_macros.svh @@
// Assertion macros shared by the keypad code alarm controller RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef KEYPAD_CODE_ALARM_CONTROLLER_MACROS_SVH
`define KEYPAD_CODE_ALARM_CONTROLLER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define KCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define KCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/core/kca_pkg.sv @@
// Package for the keypad code alarm controller: item, result, state and
// configuration types, register indexes, status codes and reset values.
// No dependencies.
package kca_pkg;

  localparam int unsigned TOUCH_W = 12;
  localparam int unsigned KEY_W   = 4;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned STEP_W  = 10;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 16;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [CFG_AW-1:0] {
    CFG_DIGIT_FIRST  = 3'd0,
    CFG_DIGIT_SECOND = 3'd1,
    CFG_DIGIT_THIRD  = 3'd2,
    CFG_DIGIT_FOURTH = 3'd3,
    CFG_THR_STEP     = 3'd4,
    CFG_THR_FLOOR    = 3'd5,
    CFG_THR_CEILING  = 3'd6
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_DISARMED = 2'd0,
    ST_ARMED    = 2'd1,
    ST_INTRUDER = 2'd2
  } alarm_status_e;

  localparam logic [KEY_W-1:0]  RST_DIGIT_FIRST  = 4'd0;
  localparam logic [KEY_W-1:0]  RST_DIGIT_SECOND = 4'd4;
  localparam logic [KEY_W-1:0]  RST_DIGIT_THIRD  = 4'd8;
  localparam logic [KEY_W-1:0]  RST_DIGIT_FOURTH = 4'd6;
  localparam logic [STEP_W-1:0] RST_THR_STEP     = 10'd100;
  localparam logic [THR_W-1:0]  RST_THR_FLOOR    = 16'd100;
  localparam logic [THR_W-1:0]  RST_THR_CEILING  = 16'd1000;
  localparam logic [THR_W-1:0]  RST_THRESHOLD    = 16'd100;
  localparam logic [THR_W-1:0]  THR_MAX          = 16'hFFFF;

  typedef struct packed {
    logic               lower_pressed;
    logic               raise_pressed;
    logic               rearm_pressed;
    logic [DIST_W-1:0]  distance_mm;
    logic               distance_valid;
    logic [TOUCH_W-1:0] touch_bits;
  } kca_item_t;

  typedef struct packed {
    logic [THR_W-1:0]  current_threshold;
    logic [DIST_W-1:0] report_distance;
    logic              report_valid;
    logic              disarm_chime;
    alarm_status_e     alarm_status;
  } kca_result_t;

  typedef struct packed {
    logic             armed;
    logic             intruder;
    logic [3:0]       progress;
    logic [THR_W-1:0] threshold;
  } kca_state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  digit_first;
    logic [KEY_W-1:0]  digit_second;
    logic [KEY_W-1:0]  digit_third;
    logic [KEY_W-1:0]  digit_fourth;
    logic [STEP_W-1:0] thr_step;
    logic [THR_W-1:0]  thr_floor;
    logic [THR_W-1:0]  thr_ceiling;
  } kca_cfg_t;

endpackage

@@ rtl/core/keypad_code_alarm_controller.sv @@
// Keypad code alarm controller top level: stream ports, configuration
// registers, input and result registers. Uses kca_pkg, kca_step and
// keypad_code_alarm_controller_macros.svh.
//
// Usage:
//   Each slave-side item is one poll of the keypad, distance sensor and
//   buttons; each poll produces exactly one master-side result item with
//   the alarm status, chime pulse, optional distance report and the
//   threshold after the step.
//   The accepted item passes the input register, then the result register,
//   before m_axis_tvalid rises. Throughput: one item per cycle, back to back,
//   while m_axis_tready stays high; one short combinational pass.
//   Stall: when the receiver holds m_axis_tready low, the result register
//   holds its item, the input register fills, and then s_axis_tready
//   drops; nothing is lost or repeated.
//   Reset: the alarm comes up armed, no intruder, code progress cleared,
//   threshold 100 mm, and the configuration registers at their defaults
//   (code 0-4-8-6, step 100, floor 100, ceiling 1000).
//   Configuration: write cfg_wdata_i to register cfg_index_i when cfg_we_i
//   is high; write only while no item is in flight.
`include "keypad_code_alarm_controller_macros.svh"

module keypad_code_alarm_controller import kca_pkg::*; #(
  parameter int unsigned KEY_COUNT = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_AW-1:0]      cfg_index_i,
  input  logic [CFG_DW-1:0]      cfg_wdata_i,
  // Poll items in
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [11:0] touch_bits, [12] distance_valid, [28:13] distance_mm,
  // [29] rearm_pressed, [30] raise_pressed, [31] lower_pressed
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Result items out
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [1:0] alarm_status, [2] disarm_chime, [3] report_valid,
  // [19:4] report_distance, [35:20] current_threshold, [39:36] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned ResW = $bits(kca_result_t);

  kca_cfg_t    cfg_q;
  kca_state_t  state_q, state_d;
  kca_item_t   item_q;
  logic        item_valid_q;
  kca_result_t res_q, res_d;
  logic        res_valid_q;
  logic        res_ready;
  logic        advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.digit_first  <= RST_DIGIT_FIRST;
      cfg_q.digit_second <= RST_DIGIT_SECOND;
      cfg_q.digit_third  <= RST_DIGIT_THIRD;
      cfg_q.digit_fourth <= RST_DIGIT_FOURTH;
      cfg_q.thr_step     <= RST_THR_STEP;
      cfg_q.thr_floor    <= RST_THR_FLOOR;
      cfg_q.thr_ceiling  <= RST_THR_CEILING;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DIGIT_FIRST:  cfg_q.digit_first  <= cfg_wdata_i[KEY_W-1:0];
        CFG_DIGIT_SECOND: cfg_q.digit_second <= cfg_wdata_i[KEY_W-1:0];
        CFG_DIGIT_THIRD:  cfg_q.digit_third  <= cfg_wdata_i[KEY_W-1:0];
        CFG_DIGIT_FOURTH: cfg_q.digit_fourth <= cfg_wdata_i[KEY_W-1:0];
        CFG_THR_STEP:     cfg_q.thr_step     <= cfg_wdata_i[STEP_W-1:0];
        CFG_THR_FLOOR:    cfg_q.thr_floor    <= cfg_wdata_i[THR_W-1:0];
        CFG_THR_CEILING:  cfg_q.thr_ceiling  <= cfg_wdata_i[THR_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Result register frees up when empty or being taken; the input register
  // advances into it, and accepts a new item when empty or when it can advance.
  assign res_ready     = !res_valid_q || m_axis_tready;
  assign advance       = item_valid_q && res_ready;
  assign s_axis_tready = !item_valid_q || res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= kca_item_t'(s_axis_tdata);
    end
  end

  kca_step #(
    .KEY_COUNT (KEY_COUNT)
  ) u_step (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Alarm state advances once per item, as the item moves into the result
  // register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.armed     <= 1'b1;
      state_q.intruder  <= 1'b0;
      state_q.progress  <= 4'b0000;
      state_q.threshold <= RST_THRESHOLD;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready) begin
      res_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - ResW)'(0), res_q};

  // A chime never comes with an intruder status: disarming clears intrusion.
  `KCA_ASSERT(a_chime_quiet,
    res_valid_q && res_q.disarm_chime |-> res_q.alarm_status != ST_INTRUDER,
    "chime with intruder status")

  // A distance report is only emitted while armed.
  `KCA_ASSERT(a_report_armed,
    res_valid_q && res_q.report_valid |-> res_q.alarm_status != ST_DISARMED,
    "distance report while disarmed")

  // No report means the distance field is zero.
  `KCA_ASSERT(a_report_zero,
    res_valid_q && !res_q.report_valid |-> res_q.report_distance == '0,
    "report distance set without a report")

  // The threshold cannot move during a step that starts and ends armed.
  `KCA_ASSERT(a_thr_hold_armed,
    advance && state_q.armed && state_d.armed |=>
      state_q.threshold == $past(state_q.threshold),
    "threshold changed while armed")

  // Arming or disarming always leaves the code progress cleared.
  `KCA_ASSERT(a_progress_on_toggle,
    state_q.armed != $past(state_q.armed) |-> state_q.progress == 4'b0000,
    "code progress left set across arm change")

  // Nothing leaves the block while reset is held.
  `KCA_ASSERT_ALWAYS(a_reset_quiet,
    !rst_ni |-> !m_axis_tvalid,
    "result valid during reset")

endmodule

@@ rtl/core/kca_step.sv @@
// One poll of the alarm: key priority encode, code tracking, distance
// check, re-arm and threshold stepping. Purely combinational; uses kca_pkg.
module kca_step import kca_pkg::*; #(
  parameter int unsigned KEY_COUNT = 12
) (
  input  kca_item_t   item_i,
  input  kca_state_t  state_i,
  input  kca_cfg_t    cfg_i,
  output kca_state_t  state_o,
  output kca_result_t result_o
);

  logic             have_key;
  logic [KEY_W-1:0] key;
  logic             chime;
  logic             report;
  logic [THR_W:0]   thr_sum;
  logic [THR_W:0]   floor_sum;
  kca_state_t       st;

  // Highest touched key wins; keys beyond KEY_COUNT are ignored.
  always_comb begin
    have_key = 1'b0;
    key      = '0;
    for (int i = 0; i < int'(TOUCH_W); i++) begin
      if (i < int'(KEY_COUNT) && item_i.touch_bits[i]) begin
        have_key = 1'b1;
        key      = KEY_W'(i);
      end
    end
  end

  always_comb begin
    st        = state_i;
    chime     = 1'b0;
    report    = 1'b0;
    thr_sum   = '0;
    floor_sum = '0;

    // Stage checks run in order so one key may advance several stages.
    if (have_key) begin
      if (key == cfg_i.digit_first && st.progress == 4'b0000) st.progress[0] = 1'b1;
      if (key == cfg_i.digit_second && st.progress == 4'b0001) st.progress[1] = 1'b1;
      if (key == cfg_i.digit_third && st.progress == 4'b0011) st.progress[2] = 1'b1;
      if (key == cfg_i.digit_fourth && st.progress == 4'b0111) st.progress[3] = 1'b1;
      if (key != cfg_i.digit_first && key != cfg_i.digit_second &&
          key != cfg_i.digit_third && key != cfg_i.digit_fourth) begin
        st.progress[2:0] = 3'b000;
      end
      if (st.progress == 4'b1111 && st.armed) begin
        st.armed    = 1'b0;
        st.intruder = 1'b0;
        st.progress = 4'b0000;
        chime       = 1'b1;
      end
    end

    if (item_i.distance_valid && st.armed) begin
      report      = 1'b1;
      st.intruder = (item_i.distance_mm <= st.threshold);
    end

    if (item_i.rearm_pressed && !st.armed) begin
      st.armed    = 1'b1;
      st.intruder = 1'b0;
      st.progress = 4'b0000;
    end

    // Raise saturates at full scale and may overshoot the ceiling.
    if (item_i.raise_pressed && !st.armed && st.threshold < cfg_i.thr_ceiling) begin
      thr_sum      = {1'b0, st.threshold} + (THR_W+1)'(cfg_i.thr_step);
      st.threshold = thr_sum[THR_W] ? THR_MAX : thr_sum[THR_W-1:0];
    end

    // Lower clamps at the floor.
    if (item_i.lower_pressed && !st.armed && st.threshold > cfg_i.thr_floor) begin
      floor_sum = {1'b0, cfg_i.thr_floor} + (THR_W+1)'(cfg_i.thr_step);
      if ({1'b0, st.threshold} >= floor_sum) begin
        st.threshold = st.threshold - THR_W'(cfg_i.thr_step);
      end else begin
        st.threshold = cfg_i.thr_floor;
      end
    end
  end

  assign state_o = st;

  always_comb begin
    result_o.alarm_status      = !st.armed ? ST_DISARMED :
                                 (st.intruder ? ST_INTRUDER : ST_ARMED);
    result_o.disarm_chime      = chime;
    result_o.report_valid      = report;
    result_o.report_distance   = report ? item_i.distance_mm : '0;
    result_o.current_threshold = st.threshold;
  end

endmodule
